/* hdl/dominant_eigen_power_iteration_macros.svh */
// Assertion macros used by the checker file of the power iteration block.
`ifndef DOMINANT_EIGEN_POWER_ITERATION_MACROS_SVH
`define DOMINANT_EIGEN_POWER_ITERATION_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define DEP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define DEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dep_pkg.sv */
// Shared constants and types for the power iteration block.
package dep_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int ACC_W   = 40;
    localparam int QUO_W   = 15;
    localparam int ITER_W  = 10;
    localparam int SIZE_W  = 4;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // Configuration register indexes.
    localparam logic CFG_ITERATION_COUNT = 1'b0;
    localparam logic CFG_MATRIX_SIZE     = 1'b1;

    // Input operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Control of the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic rd_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage

/* hdl/dep_mac.sv */
// Matrix memory and shared multiply-accumulate unit.
module dep_mac
    import dep_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [15:0]             wr_data,
    input  logic [ADDR_W-1:0]       rd_addr,
    input  mac_ctrl_t               ctrl,
    input  logic signed [15:0]      vec_elem,
    output logic signed [ACC_W-1:0] acc
);

    logic [15:0]             mem [MAX_DIM*MAX_DIM];
    logic [15:0]             rdata_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      prod;

    // Matrix memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign prod = $signed(rdata_reg) * vec_elem;

    // Accumulator for one row of the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
    end

    assign acc = acc_reg;

endmodule

/* hdl/dep_div.sv */
// Bit-serial restoring divider giving (dividend << 14) / divisor.
module dep_div
    import dep_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] dividend,
    input  logic [ACC_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [ACC_W:0]   rem_reg;
    logic [ACC_W:0]   shifted;
    logic [ACC_W:0]   dvs;
    logic [QUO_W-1:0] quo_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             bit_q;

    assign dvs     = {1'b0, divisor};
    assign shifted = {rem_reg[ACC_W-1:0], 1'b0};
    assign bit_q   = (shifted >= dvs);

    // The dividend never exceeds the divisor, so the first step yields the top bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if ({1'b0, dividend} >= dvs)
            begin
                rem_reg <= {1'b0, dividend} - dvs;
                quo_reg <= QUO_W'(1);
            end
            else
            begin
                rem_reg <= {1'b0, dividend};
                quo_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= bit_q ? (shifted - dvs) : shifted;
            quo_reg <= {quo_reg[QUO_W-2:0], bit_q};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/dominant_eigen_power_iteration.sv */
// Operation: a load writes one matrix entry; a start runs the set number of iterations.
// Each iteration uses the shared multiply-accumulate unit (states S_RD and S_MAC per term) and the
// one-bit-a-cycle divider per element; results then leave one per cycle while out_ready is high.
// Throughput: one load per cycle; no item is taken while a run or its results are pending.
// Reset clears control, sets the vector to all ones and the registers to 16 and 8.
module dominant_eigen_power_iteration
    import dep_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [2:0]          row,
    input  logic [2:0]          col,
    input  logic signed [15:0]  entry_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          element_index,
    output logic signed [15:0]  component,
    output logic [31:0]         eigen_magnitude,
    output logic                last,
    output logic                status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [9:0]          cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_MAC  = 4'd2;
    localparam logic [3:0] S_ROW  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DIVS = 4'd5;
    localparam logic [3:0] S_DIVW = 4'd6;
    localparam logic [3:0] S_NEXT = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_FAIL = 4'd9;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic [ITER_W-1:0]       iter_count_reg;
    logic [SIZE_W-1:0]       size_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic [DIM_W-1:0]        last_idx_reg;
    logic [DIM_W-1:0]        i_reg;
    logic [DIM_W-1:0]        j_reg;
    logic [ACC_W-1:0]        max_reg;
    logic signed [15:0]      vector_reg [MAX_DIM];
    logic signed [ACC_W-1:0] product_reg [MAX_DIM];
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-1:0]        acc_mag;
    logic signed [ACC_W-1:0] prod_sel;
    logic [ACC_W-1:0]        prod_mag;
    logic [QUO_W-1:0]        quotient;
    logic                    div_done;
    logic                    in_fire;
    logic                    out_fire;
    logic [DIM_W-1:0]        size_last;
    mac_ctrl_t               mac_ctrl;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT) || (state_reg == S_FAIL);
    assign out_fire  = out_valid && out_ready;
    assign cfg_ready = 1'b1;

    // Active size: zero acts as one, anything above the store saturates.
    always_comb
    begin
        if (size_reg == '0)
        begin
            size_last = '0;
        end
        else if (size_reg > SIZE_W'(MAX_DIM))
        begin
            size_last = DIM_W'(MAX_DIM - 1);
        end
        else
        begin
            size_last = DIM_W'(size_reg - SIZE_W'(1));
        end
    end

    assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign prod_sel = product_reg[i_reg];
    assign prod_mag = prod_sel[ACC_W-1] ? ACC_W'(-prod_sel) : ACC_W'(prod_sel);

    // Control of the shared multiply-accumulate unit.
    always_comb
    begin
        mac_ctrl.clear  = (state_reg == S_ROW) || (in_fire && operation == OP_START);
        mac_ctrl.rd_en  = (state_reg == S_RD);
        mac_ctrl.acc_en = (state_reg == S_MAC);
    end

    dep_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_fire && operation == OP_LOAD),
        .wr_addr  ({row, col}),
        .wr_data  (entry_value),
        .rd_addr  ({i_reg, j_reg}),
        .ctrl     (mac_ctrl),
        .vec_elem (vector_reg[j_reg]),
        .acc      (acc)
    );

    dep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIVS),
        .dividend (prod_mag),
        .divisor  (max_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && operation == OP_START)
                begin
                    state_next = (iter_count_reg == '0) ? S_OUT : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                state_next = (j_reg == last_idx_reg) ? S_ROW : S_RD;
            end
            S_ROW:
            begin
                state_next = (i_reg == last_idx_reg) ? S_CHK : S_RD;
            end
            S_CHK:
            begin
                state_next = (max_reg == '0) ? S_FAIL : S_DIVS;
            end
            S_DIVS:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = (i_reg == last_idx_reg) ? S_NEXT : S_DIVS;
                end
            end
            S_NEXT:
            begin
                state_next = (iter_reg + ITER_W'(1) == iter_count_reg) ? S_OUT : S_RD;
            end
            S_OUT:
            begin
                if (out_fire && i_reg == last_idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers, counters, vector and running maximum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iter_count_reg <= ITER_W'(16);
            size_reg       <= SIZE_W'(MAX_DIM);
            iter_reg       <= '0;
            last_idx_reg   <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            max_reg        <= '0;
            for (int k = 0; k < MAX_DIM; k++)
            begin
                vector_reg[k] <= ONE_Q14;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ITERATION_COUNT: iter_count_reg <= cfg_data;
                    CFG_MATRIX_SIZE:     size_reg       <= cfg_data[SIZE_W-1:0];
                    default:             size_reg       <= size_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && operation == OP_START)
                    begin
                        last_idx_reg <= size_last;
                        iter_reg     <= '0;
                        i_reg        <= '0;
                        j_reg        <= '0;
                        max_reg      <= '0;
                        for (int k = 0; k < MAX_DIM; k++)
                        begin
                            vector_reg[k] <= ONE_Q14;
                        end
                    end
                end
                S_MAC:
                begin
                    if (j_reg != last_idx_reg)
                    begin
                        j_reg <= j_reg + DIM_W'(1);
                    end
                end
                S_ROW:
                begin
                    j_reg <= '0;
                    if (acc_mag > max_reg)
                    begin
                        max_reg <= acc_mag;
                    end
                    i_reg <= (i_reg == last_idx_reg) ? '0 : i_reg + DIM_W'(1);
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        vector_reg[i_reg] <= prod_sel[ACC_W-1] ? -$signed({1'b0, quotient})
                                                               : $signed({1'b0, quotient});
                        i_reg <= (i_reg == last_idx_reg) ? '0 : i_reg + DIM_W'(1);
                    end
                end
                S_NEXT:
                begin
                    if (iter_reg + ITER_W'(1) != iter_count_reg)
                    begin
                        iter_reg <= iter_reg + ITER_W'(1);
                        max_reg  <= '0;
                    end
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        i_reg <= (i_reg == last_idx_reg) ? '0 : i_reg + DIM_W'(1);
                    end
                end
                default:
                begin
                    i_reg <= i_reg;
                end
            endcase
        end
    end

    // Product store, written at the end of each row.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW)
        begin
            product_reg[i_reg] <= acc;
        end
    end

    // Result fields; the magnitude is at most 30 bits wide, so it never reaches saturation.
    always_comb
    begin
        if (state_reg == S_OUT)
        begin
            element_index   = i_reg;
            component       = vector_reg[i_reg];
            eigen_magnitude = 32'(max_reg[ACC_W-1:10]);
            last            = (i_reg == last_idx_reg);
            status          = 1'b0;
        end
        else
        begin
            element_index   = '0;
            component       = '0;
            eigen_magnitude = '0;
            last            = (state_reg == S_FAIL);
            status          = (state_reg == S_FAIL);
        end
    end

endmodule

/* hdl/dep_checker.sv */
// Port-level checker for the power iteration block, with its bind.
`include "dominant_eigen_power_iteration_macros.svh"

module dep_checker
    import dep_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] component,
    input logic [31:0]        eigen_magnitude,
    input logic               last,
    input logic               status
);

    // A pending result holds until taken.
    `DEP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")

    // No input request is taken while results are pending.
    `DEP_ASSERT_IMPLY(a_busy, clk, rst_n, out_valid, !in_ready, "input taken while busy")

    // A failure is always the last result of its run.
    `DEP_ASSERT_IMPLY(a_fail_last, clk, rst_n, out_valid && status, last, "failure not last")

    // A failure carries zero fields.
    `DEP_ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_valid && status,
        component == 16'sd0 && eigen_magnitude == 32'd0, "failure fields not zero")

endmodule

bind dominant_eigen_power_iteration dep_checker u_dep_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .component       (component),
    .eigen_magnitude (eigen_magnitude),
    .last            (last),
    .status          (status)
);
